// ===== rtl/irpd_pkg.sv =====
`timescale 1ns / 1ps

package irpd_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEADER_MIN     = 3'd0,
    CFG_ONE_BIT_MIN    = 3'd1,
    CFG_REP_LEADER_MIN = 3'd2,
    CFG_REP_GAP_MIN    = 3'd3,
    CFG_REP_HOLDOFF    = 3'd4
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [15:0] LEADER_MIN_RST     = 16'd4000;
  localparam logic [15:0] ONE_BIT_MIN_RST    = 16'd1000;
  localparam logic [15:0] REP_LEADER_MIN_RST = 16'd9000;
  localparam logic [15:0] REP_GAP_MIN_RST    = 16'd2000;
  localparam logic [19:0] REP_HOLDOFF_RST    = 20'd100000;

  // Frame bit counting
  localparam logic [5:0] BITS_PER_FRAME = 6'd32;
  localparam logic [5:0] COUNT_LIMIT    = 6'd33;

  typedef struct packed {
    logic [15:0] leader_min_us;
    logic [15:0] one_bit_min_us;
    logic [15:0] repeat_leader_min_us;
    logic [15:0] repeat_gap_min_us;
    logic [19:0] repeat_holdoff_us;
  } cfg_t;

  typedef struct packed {
    logic [31:0] code;
    logic        is_repeat;
  } result_t;

endpackage

// ===== rtl/irpd_core.sv =====
`timescale 1ns / 1ps

module irpd_core
  import irpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        pin_level,
  input  logic [31:0] time_us,
  input  cfg_t        cfg,
  output logic        res_valid,
  output result_t     res
);

  logic [31:0] last_edge_time_r, last_edge_time_nxt;
  logic        last_level_r, last_level_nxt;
  logic [5:0]  bit_count_r, bit_count_nxt;
  logic [31:0] shift_code_r, shift_code_nxt;
  logic [31:0] last_interval_r, last_interval_nxt;
  logic [31:0] last_emit_time_r, last_emit_time_nxt;
  logic [31:0] last_full_code_r, last_full_code_nxt;

  logic [31:0] interval;
  logic [31:0] since_emit;
  logic        is_leader;
  logic        one_bit;
  logic [31:0] code_base;

  assign interval   = time_us - last_edge_time_r;
  assign since_emit = time_us - last_emit_time_r;
  assign is_leader  = interval >= {16'd0, cfg.leader_min_us};
  assign one_bit    = interval > {16'd0, cfg.one_bit_min_us};
  assign code_base  = is_leader ? 32'd0 : shift_code_r;

  // Decode one edge against the stored history
  always_comb begin
    last_edge_time_nxt = last_edge_time_r;
    last_level_nxt     = last_level_r;
    bit_count_nxt      = bit_count_r;
    shift_code_nxt     = shift_code_r;
    last_interval_nxt  = last_interval_r;
    last_emit_time_nxt = last_emit_time_r;
    last_full_code_nxt = last_full_code_r;
    res_valid          = 1'b0;
    res.code           = 32'd0;
    res.is_repeat      = 1'b0;
    if (accept) begin
      last_edge_time_nxt = time_us;
      last_level_nxt     = pin_level;
      last_interval_nxt  = interval;
      // falling edge: count and shift a bit
      if (last_level_r) begin
        if (is_leader) begin
          bit_count_nxt = 6'd0;
        end else if (bit_count_r < COUNT_LIMIT) begin
          bit_count_nxt = bit_count_r + 6'd1;
        end
        shift_code_nxt = {code_base[30:0], one_bit};
        if (bit_count_nxt == BITS_PER_FRAME) begin
          last_emit_time_nxt = time_us;
          last_full_code_nxt = shift_code_nxt;
          res_valid          = 1'b1;
          res.code           = shift_code_nxt;
        end else if (bit_count_nxt == 6'd1 &&
                     last_interval_r >= {16'd0, cfg.repeat_leader_min_us} &&
                     interval >= {16'd0, cfg.repeat_gap_min_us} &&
                     since_emit > {12'd0, cfg.repeat_holdoff_us}) begin
          shift_code_nxt     = last_full_code_r;
          last_emit_time_nxt = time_us;
          res_valid          = 1'b1;
          res.code           = last_full_code_r;
          res.is_repeat      = 1'b1;
        end
      end
    end
  end

  // Hold decoder history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_time_r <= 32'd0;
      last_level_r     <= 1'b1;
      bit_count_r      <= 6'd0;
      shift_code_r     <= 32'd0;
      last_interval_r  <= 32'd0;
      last_emit_time_r <= 32'd0;
      last_full_code_r <= 32'd0;
    end else begin
      last_edge_time_r <= last_edge_time_nxt;
      last_level_r     <= last_level_nxt;
      bit_count_r      <= bit_count_nxt;
      shift_code_r     <= shift_code_nxt;
      last_interval_r  <= last_interval_nxt;
      last_emit_time_r <= last_emit_time_nxt;
      last_full_code_r <= last_full_code_nxt;
    end
  end

endmodule

// ===== rtl/irpd_out_q.sv =====
`timescale 1ns / 1ps

module irpd_out_q
  import irpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    has_room,
  input  logic    rd_en,
  output logic    rd_valid,
  output result_t rd_data
);

  result_t    entry_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;

  assign has_room = count_r != 2'd2;
  assign rd_valid = count_r != 2'd0;
  assign rd_data  = entry_r[head_r];

  // Advance pointers and occupancy
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (wr_en) begin
      tail_nxt = ~tail_r;
    end
    if (rd_en) begin
      head_nxt = ~head_r;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Store a result beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[tail_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/ir_pulse_distance_decoder.sv =====
`timescale 1ns / 1ps

// Pulse-distance (NEC style) infrared remote decoder. Each input beat is one
// pin edge: the level after the edge and a free-running microsecond stamp.
// A falling edge is measured against the previous edge; a long interval
// starts a frame, shorter ones shift one bit into the code, and the 32nd bit
// emits the code with out_is_repeat low. A short frame right after a long
// leader, past the holdoff since the last emit, re-emits the last full code
// with out_is_repeat high. Rising edges only update the history. One edge is
// accepted per clock while in_ready is high: the decode is two subtracts, a
// few compares and a shift done in the accepting cycle; results go through a
// two-beat output queue, so in_ready drops only when two results wait untaken.
// A result is registered into that queue when its edge is accepted. Write the
// thresholds through cfg_* only while no edge is in flight.

module ir_pulse_distance_decoder
  import irpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_pin_level,
  input  logic [31:0]         in_time_us,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_code,
  output logic                out_is_repeat,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg_r;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t q_data;

  assign in_accept = in_valid && in_ready;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_min_us        <= LEADER_MIN_RST;
      cfg_r.one_bit_min_us       <= ONE_BIT_MIN_RST;
      cfg_r.repeat_leader_min_us <= REP_LEADER_MIN_RST;
      cfg_r.repeat_gap_min_us    <= REP_GAP_MIN_RST;
      cfg_r.repeat_holdoff_us    <= REP_HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEADER_MIN:     cfg_r.leader_min_us        <= cfg_data[15:0];
        CFG_ONE_BIT_MIN:    cfg_r.one_bit_min_us       <= cfg_data[15:0];
        CFG_REP_LEADER_MIN: cfg_r.repeat_leader_min_us <= cfg_data[15:0];
        CFG_REP_GAP_MIN:    cfg_r.repeat_gap_min_us    <= cfg_data[15:0];
        CFG_REP_HOLDOFF:    cfg_r.repeat_holdoff_us    <= cfg_data[19:0];
        default:            ;
      endcase
    end
  end

  // Decode the edge
  irpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .pin_level (in_pin_level),
    .time_us   (in_time_us),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Queue result beats
  irpd_out_q u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res),
    .has_room (in_ready),
    .rd_en    (out_valid && out_ready),
    .rd_valid (out_valid),
    .rd_data  (q_data)
  );

  assign out_code      = q_data.code;
  assign out_is_repeat = q_data.is_repeat;

endmodule
